[hdl/tks_pkg.sv]
`default_nettype none

package tks_pkg;

  // Fixed field widths of the stream payloads.
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned TC_W    = 5;

  // Default sizing of the block.
  localparam int unsigned TOP_MAX_DEF   = 16;
  localparam int unsigned MAX_ITEMS_DEF = 1024;

  // Reset value of the top_count register.
  localparam logic [TC_W-1:0] TOP_COUNT_RST = TC_W'(5);

  // Register indexes on the configuration port.
  localparam logic REG_TOP_COUNT = 1'b0;

  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic                      last_score;
  } tks_in_t;

  typedef struct packed {
    logic [IDX_W-1:0]          class_index;
    logic signed [SCORE_W-1:0] best_score;
    logic                      rank_last;
    logic                      overflow;
  } tks_out_t;

  // One kept entry of the sorted row.
  typedef struct packed {
    logic signed [SCORE_W-1:0] score;
    logic [IDX_W-1:0]          idx;
  } tks_entry_t;

  // Row-wide command shared by all cells.
  typedef struct packed {
    logic insert;
    logic shift;
  } tks_cell_ctl_t;

  typedef enum logic {
    ST_COLLECT,
    ST_DRAIN
  } tks_state_e;

endpackage

`default_nettype wire

[hdl/tks_cell.sv]
`default_nettype none

module tks_cell
  import tks_pkg::*;
(
  input  wire logic          clk_i,
  input  wire tks_cell_ctl_t ctl_i,
  input  wire logic          occupied_i,
  input  wire tks_entry_t    new_i,
  input  wire tks_entry_t    left_i,
  input  wire logic          left_take_i,
  input  wire tks_entry_t    right_i,
  output tks_entry_t         entry_o,
  output logic               take_o
);

  tks_entry_t entry_q, entry_d;

  // The new score belongs at or above this slot when the slot is empty or
  // holds a strictly lower score; equal scores keep the earlier index first.
  assign take_o = ~occupied_i | (new_i.score > entry_q.score);

  // On insert a slot either takes its left neighbor's entry (shift down),
  // takes the new entry, or holds. On drain it takes its right neighbor's.
  always_comb begin
    entry_d = entry_q;
    if (ctl_i.insert) begin
      if (left_take_i) begin
        entry_d = left_i;
      end else if (take_o) begin
        entry_d = new_i;
      end
    end else if (ctl_i.shift) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

[hdl/tks_regs.sv]
`default_nettype none

module tks_regs
  import tks_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  output logic [TC_W-1:0]      top_count_o
);

  logic [TC_W-1:0] top_count_q;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & (paddr[2] == REG_TOP_COUNT);

  // Register write on the access cycle of a transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TOP_COUNT_RST;
    end else if (wr_en) begin
      top_count_q <= pwdata[TC_W-1:0];
    end
  end

  // Read data; addresses past the register list read as zero.
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_TOP_COUNT) begin
      prdata = 32'(top_count_q);
    end
  end

  assign top_count_o = top_count_q;

endmodule

`default_nettype wire

[hdl/top_k_score_selector_core.sv]
`default_nettype none

// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+----------------------------------
// in       | input     | in_valid_i / in_ready_o | tks_in_t  (score, last_score)
// out      | output    | out_valid_o/out_ready_i | tks_out_t (index, score, flags)
// apb      | input     | psel/penable/pready     | top_count at byte address 0
//
// While collecting, one score is taken per cycle and, up to MAX_ITEMS per
// vector, inserted into a row of TOP_MAX compare-and-shift cells in that same cycle.
// After the transfer of the score flagged last, input stalls while the row
// shifts out toward cell 0, one result per output transfer: a vector of N kept
// scores gives k = min(top_count, N, TOP_MAX) results, a top_count of 0 counting as 1.
// Output stalls simply hold the row. Reset empties the row through the
// item count; no clearing pass is needed.

module top_k_score_selector_core
  import tks_pkg::*;
#(
  parameter int unsigned TOP_MAX   = TOP_MAX_DEF,
  parameter int unsigned MAX_ITEMS = MAX_ITEMS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire tks_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output tks_out_t         out_data_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int unsigned CntW    = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CntExtW = (CntW > IDX_W) ? CntW : IDX_W;
  localparam int unsigned KW      = $clog2(TOP_MAX + 1);

  tks_state_e     state_q, state_d;
  logic [CntW-1:0] count_q;
  logic            ovf_seen_q;
  logic [KW-1:0]   remain_q;
  logic            drain_ovf_q;

  logic [TC_W-1:0]  top_count;
  logic             in_fire, out_fire, full;
  logic [KW-1:0]    k_run;
  logic [CntExtW-1:0] count_ext;
  tks_cell_ctl_t    ctl;
  tks_entry_t       new_entry;

  tks_entry_t entries   [TOP_MAX];
  tks_entry_t left_ent  [TOP_MAX];
  tks_entry_t right_ent [TOP_MAX];
  logic       takes     [TOP_MAX];
  logic       left_take [TOP_MAX];
  logic       occupied  [TOP_MAX];

  tks_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .top_count_o (top_count)
  );

  assign in_fire  = in_valid_i & in_ready_o;
  assign out_fire = out_valid_o & out_ready_i;
  assign full     = (count_q == CntW'(MAX_ITEMS));

  // The arrival index is the current count; only its low bits are kept.
  assign count_ext       = CntExtW'(count_q);
  assign new_entry.score = in_data_i.score;
  assign new_entry.idx   = count_ext[IDX_W-1:0];

  assign ctl.insert = in_fire & ~full;
  assign ctl.shift  = out_fire;

  // Row of cells, best entry in cell 0.
  for (genvar i = 0; i < TOP_MAX; i++) begin : g_row
    assign occupied[i] = (int'(count_q) > i);

    if (i == 0) begin : g_head
      assign left_ent[i]  = new_entry;
      assign left_take[i] = 1'b0;
    end else begin : g_body
      assign left_ent[i]  = entries[i-1];
      assign left_take[i] = takes[i-1];
    end

    if (i == TOP_MAX - 1) begin : g_tail
      assign right_ent[i] = entries[i];
    end else begin : g_mid
      assign right_ent[i] = entries[i+1];
    end

    tks_cell u_cell (
      .clk_i       (clk_i),
      .ctl_i       (ctl),
      .occupied_i  (occupied[i]),
      .new_i       (new_entry),
      .left_i      (left_ent[i]),
      .left_take_i (left_take[i]),
      .right_i     (right_ent[i]),
      .entry_o     (entries[i]),
      .take_o      (takes[i])
    );
  end

  // Number of results for the vector that ends with this transfer.
  always_comb begin
    int unsigned cnt_after;
    int unsigned have;
    int unsigned want;
    int unsigned k;
    cnt_after = full ? MAX_ITEMS : int'(count_q) + 1;
    have      = (cnt_after < TOP_MAX) ? cnt_after : TOP_MAX;
    if (top_count == '0) begin
      want = 1;
    end else if (int'(top_count) > TOP_MAX) begin
      want = TOP_MAX;
    end else begin
      want = int'(top_count);
    end
    k     = (want < have) ? want : have;
    k_run = KW'(k);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_COLLECT: begin
        if (in_fire && in_data_i.last_score) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (out_fire && (remain_q == KW'(1))) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_COLLECT: in_ready_o  = 1'b1;
      ST_DRAIN:   out_valid_o = 1'b1;
      default: begin
        in_ready_o  = 1'b0;
        out_valid_o = 1'b0;
      end
    endcase
  end

  // Vector bookkeeping and drain counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      count_q     <= '0;
      ovf_seen_q  <= 1'b0;
      remain_q    <= '0;
      drain_ovf_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        if (in_data_i.last_score) begin
          count_q     <= '0;
          ovf_seen_q  <= 1'b0;
          remain_q    <= k_run;
          drain_ovf_q <= ovf_seen_q | full;
        end else if (full) begin
          ovf_seen_q <= 1'b1;
        end else begin
          count_q <= count_q + CntW'(1);
        end
      end else if (out_fire) begin
        remain_q <= remain_q - KW'(1);
      end
    end
  end

  // Result comes straight from the head cell.
  assign out_data_o.class_index = entries[0].idx;
  assign out_data_o.best_score  = entries[0].score;
  assign out_data_o.rank_last   = (remain_q == KW'(1));
  assign out_data_o.overflow    = drain_ovf_q;

endmodule

`default_nettype wire

[tb/tb_top_k_score_selector_core.sv]
`default_nettype none

module tb_top_k_score_selector_core;
  import tks_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ROW_DEPTH   = TOP_MAX_DEF;
  localparam int unsigned VECTOR_CAP  = MAX_ITEMS_DEF;
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int unsigned PHASE_SCORES = 45;

  localparam logic signed [SCORE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SCORE_W-1:0] S_MIN = 32'sh8000_0000;

  // Directed row: one score transfer, with a hand-written single result where
  // the vector is short enough to read it off directly.
  typedef struct packed {
    tks_in_t  item;
    logic     has_exp;
    tks_out_t exp_res;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 22;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    // Single-score vectors at the extremes and with alternating bit patterns.
    {S_MAX, 1'b1, 1'b1, 10'd0, S_MAX, 1'b1, 1'b0},
    {S_MIN, 1'b1, 1'b1, 10'd0, S_MIN, 1'b1, 1'b0},
    {32'sd0, 1'b1, 1'b1, 10'd0, 32'sd0, 1'b1, 1'b0},
    {32'sh5555_5555, 1'b1, 1'b1, 10'd0, 32'sh5555_5555, 1'b1, 1'b0},
    {32'shAAAA_AAAA, 1'b1, 1'b1, 10'd0, 32'shAAAA_AAAA, 1'b1, 1'b0},
    // Ties, negatives and extremes mixed; more scores than reported results.
    {32'sd5, 1'b0, 45'd0},
    {32'sd5, 1'b0, 45'd0},
    {-32'sd1, 1'b0, 45'd0},
    {S_MAX, 1'b0, 45'd0},
    {S_MIN, 1'b0, 45'd0},
    {32'sd5, 1'b0, 45'd0},
    {32'sh0001_0000, 1'b0, 45'd0},
    {-32'sd3, 1'b1, 45'd0},
    // Fewer scores than top_count, arriving in rising order.
    {32'sd1, 1'b0, 45'd0},
    {32'sd2, 1'b0, 45'd0},
    {32'sd3, 1'b1, 45'd0},
    // All scores equal: the earlier index must stay ahead.
    {32'sd7, 1'b0, 45'd0},
    {32'sd7, 1'b0, 45'd0},
    {32'sd7, 1'b0, 45'd0},
    {32'sd7, 1'b0, 45'd0},
    {32'sd7, 1'b0, 45'd0},
    {32'sd7, 1'b1, 45'd0}
  };

  localparam logic [TC_W-1:0] TC_PLAN [7] = '{5'd0, 5'd16, 5'd31, 5'd1, 5'd17, 5'd3, 5'd5};

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  tks_in_t     in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  tks_out_t    out_data_o;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  top_k_score_selector_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow of the block: sorted row, vector bookkeeping and the register.
  logic signed [SCORE_W-1:0] row_score [ROW_DEPTH];
  logic [IDX_W-1:0]          row_idx   [ROW_DEPTH];
  int unsigned               scores_in_vector;
  bit                        vector_dropped;
  logic [TC_W-1:0]           top_count_shadow;
  tks_out_t                  ranked_results [$];

  bit          idle_en;
  int          ready_hold;
  int unsigned mismatches;
  int unsigned scores_sent;
  int unsigned vectors_sent;
  int unsigned results_checked;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Gap length for either side: mostly none, some short, a few long.
  function automatic int pick_gap();
    int r;
    if (!idle_en) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [SCORE_W-1:0] draw_score(int mode);
    case (mode)
      0: begin
        return $urandom;
      end
      1: begin
        return int'($urandom_range(0, 8)) - 4;
      end
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'sh0001_8000;
          1: return -32'sh0000_4000;
          default: return 32'sh0000_0001;
        endcase
      end
      default: begin
        case ($urandom_range(0, 3))
          0: return S_MAX;
          1: return S_MIN;
          2: return 32'sd0;
          default: return -32'sd1;
        endcase
      end
    endcase
  endfunction

  // Insert one accepted score into the shadow row and, on the last score of
  // a vector, queue the ranked results best first and clear the vector.
  function automatic void rank_score(tks_in_t it);
    int unsigned pos;
    int unsigned want;
    int unsigned have;
    int unsigned k;
    tks_out_t    res;
    if (scores_in_vector < VECTOR_CAP) begin
      pos = (scores_in_vector < ROW_DEPTH) ? scores_in_vector : ROW_DEPTH;
      while (pos > 0 && row_score[pos-1] < it.score) begin
        if (pos < ROW_DEPTH) begin
          row_score[pos] = row_score[pos-1];
          row_idx[pos]   = row_idx[pos-1];
        end
        pos--;
      end
      if (pos < ROW_DEPTH) begin
        row_score[pos] = it.score;
        row_idx[pos]   = IDX_W'(scores_in_vector);
      end
      scores_in_vector++;
    end else begin
      vector_dropped = 1'b1;
    end
    if (!it.last_score) begin
      return;
    end
    want = (top_count_shadow == 0) ? 1 : top_count_shadow;
    if (want > ROW_DEPTH) begin
      want = ROW_DEPTH;
    end
    have = (scores_in_vector < ROW_DEPTH) ? scores_in_vector : ROW_DEPTH;
    k = (want < have) ? want : have;
    for (int unsigned i = 0; i < k; i++) begin
      res.class_index = row_idx[i];
      res.best_score  = row_score[i];
      res.rank_last   = (i + 1 == k);
      res.overflow    = vector_dropped;
      ranked_results  = {ranked_results, res};
    end
    vectors_sent++;
    scores_in_vector = 0;
    vector_dropped   = 1'b0;
  endfunction

  // Offer one score after an optional gap and hold it until its transfer.
  // Called and returning just after a falling edge.
  task automatic push_score(tks_in_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (!in_ready_o);
    rank_score(it);
    scores_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_vector(int unsigned len, int mode);
    tks_in_t it;
    for (int unsigned j = 0; j < len; j++) begin
      it.score      = draw_score(mode);
      it.last_score = (j + 1 == len);
      push_score(it);
    end
  endtask

  // Wait until every queued result has gone out, then let the block idle.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (ranked_results.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Write top_count over the configuration port and read it back.
  task automatic program_top_count(logic [TC_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_TOP_COUNT, 2'b00};
    pwdata  <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    top_count_shadow = value;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(value)) begin
      $error("top_count readback: expected %0d, actual %0d", value, prdata);
      mismatches++;
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result side stalls on its own schedule.
  always @(negedge clk_i) begin
    if (!idle_en || ready_hold == 0) begin
      out_ready_i <= 1'b1;
      ready_hold = pick_gap();
    end else begin
      out_ready_i <= 1'b0;
      ready_hold--;
    end
  end

  // Compare every result transfer with the oldest queued expectation.
  always @(posedge clk_i) begin
    tks_out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (ranked_results.size() == 0) begin
        $error("unexpected result: index %0d score %0d", out_data_o.class_index,
               out_data_o.best_score);
        mismatches++;
      end else begin
        exp_res = ranked_results.pop_front();
        results_checked++;
        if (out_data_o.class_index !== exp_res.class_index) begin
          $error("class_index: expected %0d, actual %0d", exp_res.class_index,
                 out_data_o.class_index);
          mismatches++;
        end
        if (out_data_o.best_score !== exp_res.best_score) begin
          $error("best_score: expected %0d, actual %0d", exp_res.best_score,
                 out_data_o.best_score);
          mismatches++;
        end
        if (out_data_o.rank_last !== exp_res.rank_last) begin
          $error("rank_last: expected %0b, actual %0b", exp_res.rank_last,
                 out_data_o.rank_last);
          mismatches++;
        end
        if (out_data_o.overflow !== exp_res.overflow) begin
          $error("overflow: expected %0b, actual %0b", exp_res.overflow,
                 out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Timeout after %0d cycles with %0d results pending", CYCLE_LIMIT,
             ranked_results.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int unsigned phase_count;
    int          r;
    int          mode;
    int unsigned len;
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    in_data_i        = '0;
    out_ready_i      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    idle_en          = 1'b1;
    ready_hold       = 0;
    mismatches       = 0;
    scores_sent      = 0;
    vectors_sent     = 0;
    results_checked  = 0;
    scores_in_vector = 0;
    vector_dropped   = 1'b0;
    top_count_shadow = TOP_COUNT_RST;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table under the reset value of top_count.
    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      push_score(DIR_TABLE[i].item);
      if (DIR_TABLE[i].has_exp) begin
        ranked_results[ranked_results.size()-1] = DIR_TABLE[i].exp_res;
      end
    end
    wait_drained();

    // Random vectors under a sequence of top_count settings.
    for (int p = 0; p < 8; p++) begin
      program_top_count((p < 7) ? TC_PLAN[p] : TC_W'($urandom_range(0, 31)));
      idle_en = ($urandom_range(0, 3) != 0);
      phase_count = 0;
      while (phase_count < PHASE_SCORES) begin
        r = $urandom_range(0, 99);
        len = (r < 10) ? 1 : (r < 85) ? $urandom_range(2, 20) : $urandom_range(21, 48);
        r = $urandom_range(0, 99);
        mode = (r < 50) ? 0 : (r < 70) ? 1 : (r < 85) ? 2 : 3;
        send_vector(len, mode);
        phase_count += len;
      end
      wait_drained();
    end

    $display("Sent %0d scores in %0d vectors with random gaps on both sides.",
             scores_sent, vectors_sent);
    $display("Checked %0d ranked results over top_count settings 0 to 31.",
             results_checked);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
hdl/tks_pkg.sv
hdl/tks_cell.sv
hdl/tks_regs.sv
hdl/top_k_score_selector_core.sv
tb/tb_top_k_score_selector_core.sv
